/* rtl/lfc_pkg.sv */
// Shared types, class codes and match constants for the log token field classifier.
// Used by every module of the block; depends on nothing.
package lfc_pkg;

  // Field class codes
  localparam logic [3:0] CLS_TIMESTAMP = 4'd0;
  localparam logic [3:0] CLS_IP        = 4'd1;
  localparam logic [3:0] CLS_ENDPOINT  = 4'd2;
  localparam logic [3:0] CLS_METHOD    = 4'd3;
  localparam logic [3:0] CLS_VERSION   = 4'd4;
  localparam logic [3:0] CLS_MS        = 4'd5;
  localparam logic [3:0] CLS_STATUS    = 4'd6;
  localparam logic [3:0] CLS_TEXT      = 4'd7;
  localparam logic [3:0] CLS_ERROR     = 4'd8;

  // Byte constants
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [15:0] MS_SUFFIX  = 16'h6D73;  // "ms"

  // Method words, bit order GET, POST, PUT, DELETE, PATCH
  localparam int NUM_METHODS = 5;
  localparam logic [7:0] METHOD_WORDS [0:4][0:5] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00},
    '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45},
    '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h00}
  };
  localparam logic [2:0] METHOD_LENS [0:4] = '{3'd3, 3'd4, 3'd3, 3'd6, 3'd5};

  // "HTTP/" prefix
  localparam logic [2:0] HTTP_LEN = 3'd5;
  localparam logic [7:0] HTTP_WORD [0:4] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

  // Status code range
  localparam logic [30:0] STATUS_MIN = 31'd100;
  localparam logic [30:0] STATUS_MAX = 31'd599;

  // One input request
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_token;
    logic       empty_token;
  } lfc_item_t;

  // Running per-token summary
  typedef struct packed {
    logic [7:0]  first_char;
    logic [2:0]  length_sat;
    logic [1:0]  dot_count_sat;
    logic        all_digit_or_dot;
    logic        all_digit;
    logic        prefix_all_digit;
    logic [15:0] recent_bytes;
    logic [1:0]  recent_digit_flags;
    logic [4:0]  method_match_vector;
    logic        http_prefix_match;
    logic [30:0] numeric_value;
    logic        numeric_overflow;
  } lfc_state_t;

  localparam lfc_state_t STATE_RESET = '{
    first_char:          8'd0,
    length_sat:          3'd0,
    dot_count_sat:       2'd0,
    all_digit_or_dot:    1'b1,
    all_digit:           1'b1,
    prefix_all_digit:    1'b1,
    recent_bytes:        16'd0,
    recent_digit_flags:  2'd0,
    method_match_vector: 5'b11111,
    http_prefix_match:   1'b1,
    numeric_value:       31'd0,
    numeric_overflow:    1'b0
  };

endpackage

/* rtl/log_token_field_classifier_top.sv */
// Log token field classifier: sorts each token of a log line into a field class.
//
// Input channel (in_valid / in_stall): one byte of a token per request, with
// in_end_of_token on the last byte. in_empty_token ends the token without a
// byte; if no bytes are pending the class is error.
// Result channel (out_valid / out_stall): one out_field_class per token.
//
// A token end passes the input register and then the result register before
// out_valid rises with its class; a stalled result can hold the token end in
// the input register between the two.
// Throughput: one byte per cycle while no token end waits on a stalled result,
// set by the single update pass between the input register and the token summary registers.
// A stalled result holds its value; bytes that do not end a token still flow
// while it waits, and a token end waits in the input register, with in_stall
// high, until the result register frees.
// Reset (rst_n low, synchronous) empties both registers and clears the
// token summary to the start of an empty token.
// Depends on lfc_pkg, lfc_in_stage and lfc_token_track.
module log_token_field_classifier_top
  import lfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_token,
  input  logic       in_empty_token,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_field_class
);

  lfc_item_t  in_item, item;
  logic       item_valid, go, fin;
  logic [3:0] field_class;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_class_r;
  logic       out_free;

  assign in_item = '{char_byte: in_char_byte, end_of_token: in_end_of_token,
                     empty_token: in_empty_token};

  lfc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .go         (go),
    .item_valid (item_valid),
    .item       (item)
  );

  lfc_token_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .go          (go),
    .fin         (fin),
    .field_class (field_class)
  );

  // A token end moves only when the result register can take it
  assign out_free = ~out_valid_r | ~out_stall;
  assign go       = item_valid & (~fin | out_free);

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && fin) begin
      out_class_r <= field_class;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_class = out_class_r;

endmodule

/* rtl/lfc_in_stage.sv */
// Input register of the classifier: holds one request until the token tracker takes it.
// Depends on lfc_pkg.
module lfc_in_stage
  import lfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lfc_item_t in_item,
  input  logic      go,
  output logic      item_valid,
  output lfc_item_t item
);

  logic      valid_r, valid_nxt;
  lfc_item_t item_r;
  logic      take;

  // Stall only while the held request cannot move on
  assign in_stall = valid_r & ~go;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/lfc_token_track.sv */
// Per-token summary registers, their byte update and the end-of-token class decision.
// Depends on lfc_pkg.
module lfc_token_track
  import lfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lfc_item_t  item,
  input  logic       go,
  output logic       fin,
  output logic [3:0] field_class
);

  lfc_state_t st_r, st_nxt, upd;
  logic       dig;
  logic [2:0] pos;
  logic [7:0] c;
  logic [34:0] acc;
  logic       method_hit;

  assign c   = item.char_byte;
  assign pos = st_r.length_sat;
  assign dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign fin = item.empty_token | item.end_of_token;

  // Decimal accumulate: value*10 + digit
  assign acc = ({4'd0, st_r.numeric_value} << 3) + ({4'd0, st_r.numeric_value} << 1)
             + {31'd0, 4'(c - CH_ZERO)};

  // Fold the byte into the summary
  always_comb begin
    upd = st_r;
    if (!item.empty_token) begin
      if (pos == 3'd0) begin
        upd.first_char = c;
      end
      if (c == CH_DOT && st_r.dot_count_sat != 2'd3) begin
        upd.dot_count_sat = st_r.dot_count_sat + 2'd1;
      end
      if (!(dig || c == CH_DOT)) begin
        upd.all_digit_or_dot = 1'b0;
      end
      if (!dig) begin
        upd.all_digit = 1'b0;
      end
      // older recent byte leaves the suffix window
      if (pos >= 3'd2 && !st_r.recent_digit_flags[1]) begin
        upd.prefix_all_digit = 1'b0;
      end
      upd.recent_bytes       = {st_r.recent_bytes[7:0], c};
      upd.recent_digit_flags = {st_r.recent_digit_flags[0], dig};
      for (int w = 0; w < NUM_METHODS; w++) begin
        if (pos >= METHOD_LENS[w]) begin
          upd.method_match_vector[w] = 1'b0;
        end else if (METHOD_WORDS[w][pos] != c) begin
          upd.method_match_vector[w] = 1'b0;
        end
      end
      if (pos < HTTP_LEN) begin
        if (HTTP_WORD[pos] != c) begin
          upd.http_prefix_match = 1'b0;
        end
      end
      if (dig && !st_r.numeric_overflow) begin
        if (|acc[34:31]) begin
          upd.numeric_overflow = 1'b1;
        end else begin
          upd.numeric_value = acc[30:0];
        end
      end
      if (pos != 3'd7) begin
        upd.length_sat = pos + 3'd1;
      end
    end
  end

  // Exact method match on the updated summary
  always_comb begin
    method_hit = 1'b0;
    for (int w = 0; w < NUM_METHODS; w++) begin
      if (upd.method_match_vector[w] && upd.length_sat == METHOD_LENS[w]) begin
        method_hit = 1'b1;
      end
    end
  end

  // Priority classification
  always_comb begin
    if (upd.length_sat == 3'd0) begin
      field_class = CLS_ERROR;
    end else if (upd.first_char == CH_LBRACKET) begin
      field_class = CLS_TIMESTAMP;
    end else if (upd.dot_count_sat == 2'd3 && upd.all_digit_or_dot) begin
      field_class = CLS_IP;
    end else if (upd.first_char == CH_SLASH) begin
      field_class = CLS_ENDPOINT;
    end else if (method_hit) begin
      field_class = CLS_METHOD;
    end else if (upd.length_sat >= 3'd5 && upd.http_prefix_match) begin
      field_class = CLS_VERSION;
    end else if (upd.length_sat > 3'd2 && upd.recent_bytes == MS_SUFFIX
                 && upd.prefix_all_digit) begin
      field_class = CLS_MS;
    end else if (upd.all_digit && upd.numeric_overflow) begin
      field_class = CLS_ERROR;
    end else if (upd.all_digit && upd.numeric_value >= STATUS_MIN
                 && upd.numeric_value <= STATUS_MAX) begin
      field_class = CLS_STATUS;
    end else begin
      field_class = CLS_TEXT;
    end
  end

  // Clear for the next token once this one ends
  always_comb begin
    st_nxt = st_r;
    if (go) begin
      st_nxt = fin ? STATE_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/lfc_checker.sv */
// Port-level checks for the log token field classifier, bound to the top level.
// Depends on lfc_pkg and log_token_field_classifier_top.
module lfc_checker
  import lfc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_end_of_token,
  input logic       in_empty_token,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_field_class
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_class))
    else $error("stalled result changed");

  // Class code stays within the defined set
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_field_class <= CLS_ERROR)
    else $error("undefined class code");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A new result follows an accepted token end request
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && (in_end_of_token || in_empty_token), 2))
    else $error("result without a token end request");

endmodule

bind log_token_field_classifier_top lfc_checker u_lfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_end_of_token (in_end_of_token),
  .in_empty_token  (in_empty_token),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_field_class (out_field_class)
);
